// File: src/budgeted_residency_planner_defines.svh
// Assertion macros used by the planner module.
`ifndef BUDGETED_RESIDENCY_PLANNER_DEFINES_SVH
`define BUDGETED_RESIDENCY_PLANNER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define BRP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define BRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

// File: src/brp_pkg.sv
// Types and constants of the residency planner.
package brp_pkg;
  typedef enum logic [1:0] {
    DEC_KEEP   = 2'd0,
    DEC_LOAD   = 2'd1,
    DEC_EVICT  = 2'd2,
    DEC_REJECT = 2'd3
  } decision_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_WAIT,
    ST_SORT_CMP,
    ST_SORT_WR,
    ST_SEL_RD,
    ST_SEL_WAIT,
    ST_SEL_CHK,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT_OUT
  } state_e;

  localparam int unsigned ImpBits = 16;
endpackage

// File: src/brp_if.sv
// Valid/ready channel interfaces carrying asset and decision payloads.
interface brp_asset_if #(
  parameter int unsigned KEY_BITS  = 32,
  parameter int unsigned COST_BITS = 48
) ();
  logic                  valid;
  logic                  ready;
  logic [KEY_BITS-1:0]   asset_key;
  logic [COST_BITS-1:0]  asset_cost;
  logic signed [15:0]    importance;
  logic                  visible;
  logic                  resident;
  logic                  batch_last;
  modport source (output valid, asset_key, asset_cost, importance, visible, resident,
                  batch_last, input ready);
  modport sink (input valid, asset_key, asset_cost, importance, visible, resident,
                batch_last, output ready);
endinterface

interface brp_decision_if #(
  parameter int unsigned KEY_BITS  = 32,
  parameter int unsigned COST_BITS = 48
) ();
  logic                  valid;
  logic                  ready;
  logic [KEY_BITS-1:0]   out_key;
  logic [COST_BITS-1:0]  out_cost;
  logic signed [15:0]    out_importance;
  logic                  out_visible;
  logic [1:0]            decision;
  logic                  out_last;
  modport source (output valid, out_key, out_cost, out_importance, out_visible, decision,
                  out_last, input ready);
  modport sink (input valid, out_key, out_cost, out_importance, out_visible, decision,
                out_last, output ready);
endinterface

// File: src/brp_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read.
module brp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: src/budgeted_residency_planner.sv
// Operation: a batch of N assets loads at one per cycle; the close then runs an
// insertion sort that compares each asset against earlier ones and places it, a greedy
// selection pass over the sorted order and emission of one decision per asset.
// Batches: one batch at a time; a new batch loads only after its last decision is emitted.
// Reset: asynchronous, active low; clears the control state, marks and budget.
// The asset memories hold no reset value and are only read after being written.
`include "budgeted_residency_planner_defines.svh"
module budgeted_residency_planner
  import brp_pkg::*;
#(
  parameter int unsigned MAX_ASSETS = 64,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned COST_BITS  = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [COST_BITS+5:0]   cfg_wdata_i,
  brp_asset_if.sink              in_if,
  brp_decision_if.source         out_if
);
  localparam int unsigned IdxBits = $clog2(MAX_ASSETS);
  localparam int unsigned CntBits = IdxBits + 1;
  localparam int unsigned BudBits = COST_BITS + 6;
  localparam int unsigned RecBits = KEY_BITS + COST_BITS + ImpBits + 2;

  state_e state_q, state_d;
  logic [BudBits-1:0] budget_q;
  logic [CntBits-1:0] count_q, count_d;
  logic [CntBits-1:0] i_q, i_d;
  logic [CntBits-1:0] j_q, j_d;
  logic [BudBits:0]   used_q, used_d;
  logic [MAX_ASSETS-1:0] marks_q, marks_d;
  logic [RecBits-1:0] cur_rec_q, cur_rec_d;

  // Asset record memory: key, cost, importance, resident, visible.
  logic               rec_we;
  logic [IdxBits-1:0] rec_waddr, rec_raddr;
  logic [RecBits-1:0] rec_wdata, rec_rdata;
  // Sort order memory: arrival index and a shadow of the record at each order slot.
  logic               ord_we;
  logic [IdxBits-1:0] ord_waddr, ord_raddr;
  logic [IdxBits+RecBits-1:0] ord_wdata, ord_rdata;

  brp_ram #(.WIDTH(RecBits), .DEPTH(MAX_ASSETS)) u_rec_ram (
    .clk_i, .we_i(rec_we), .waddr_i(rec_waddr), .wdata_i(rec_wdata),
    .raddr_i(rec_raddr), .rdata_o(rec_rdata));
  brp_ram #(.WIDTH(IdxBits + RecBits), .DEPTH(MAX_ASSETS)) u_ord_ram (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(ord_wdata),
    .raddr_i(ord_raddr), .rdata_o(ord_rdata));

  // Record field views.
  function automatic logic [KEY_BITS-1:0] rec_key(input logic [RecBits-1:0] r);
    rec_key = r[RecBits-1 -: KEY_BITS];
  endfunction
  function automatic logic [COST_BITS-1:0] rec_cost(input logic [RecBits-1:0] r);
    rec_cost = r[COST_BITS+ImpBits+1 -: COST_BITS];
  endfunction
  function automatic logic signed [ImpBits-1:0] rec_imp(input logic [RecBits-1:0] r);
    rec_imp = r[ImpBits+1:2];
  endfunction

  // Sorting compare: current record (arrival i) against the entry at order slot j-1.
  logic [RecBits-1:0] oth_rec;
  logic               cur_first;
  assign oth_rec = ord_rdata[RecBits-1:0];
  always_comb begin
    logic va, vb;
    va = cur_rec_q[0];
    vb = oth_rec[0];
    if (va != vb) cur_first = va;
    else if (rec_imp(cur_rec_q) != rec_imp(oth_rec))
      cur_first = rec_imp(cur_rec_q) > rec_imp(oth_rec);
    else if (rec_key(cur_rec_q) != rec_key(oth_rec))
      cur_first = rec_key(cur_rec_q) < rec_key(oth_rec);
    else cur_first = 1'b0;
  end

  logic in_fire, out_fire, last_in;
  assign in_fire = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign last_in = in_if.batch_last || (count_q == CntBits'(MAX_ASSETS - 1));

  logic [BudBits:0] sum_w;
  assign sum_w = used_q + (BudBits+1)'(rec_cost(ord_rdata[RecBits-1:0]));

  // Budget register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= '0;
    end else if (cfg_we_i) begin
      budget_q <= cfg_wdata_i;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:      if (in_fire && last_in) state_d = ST_SORT_RD;
      ST_SORT_RD:   state_d = (j_q == '0) ? ST_SORT_WR : ST_SORT_WAIT;
      ST_SORT_WAIT: state_d = ST_SORT_CMP;
      ST_SORT_CMP:  state_d = cur_first ? ST_SORT_RD : ST_SORT_WR;
      ST_SORT_WR:   state_d = (i_q + 1'b1 == count_q) ? ST_SEL_RD : ST_SORT_RD;
      ST_SEL_RD:    state_d = ST_SEL_WAIT;
      ST_SEL_WAIT:  state_d = ST_SEL_CHK;
      ST_SEL_CHK:   state_d = (i_q + 1'b1 == count_q) ? ST_EMIT_RD : ST_SEL_RD;
      ST_EMIT_RD:   state_d = ST_EMIT_WAIT;
      ST_EMIT_WAIT: state_d = ST_EMIT_OUT;
      ST_EMIT_OUT:  if (out_fire) state_d = (i_q + 1'b1 == count_q) ? ST_LOAD : ST_EMIT_RD;
      default:      state_d = ST_LOAD;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    count_d = count_q; i_d = i_q; j_d = j_q; used_d = used_q; marks_d = marks_q;
    cur_rec_d = cur_rec_q;
    rec_we = 1'b0; rec_waddr = count_q[IdxBits-1:0];
    rec_wdata = {in_if.asset_key, in_if.asset_cost, in_if.importance,
                 in_if.resident, in_if.visible};
    rec_raddr = i_q[IdxBits-1:0];
    ord_we = 1'b0; ord_waddr = j_q[IdxBits-1:0];
    ord_wdata = {i_q[IdxBits-1:0], cur_rec_q};
    ord_raddr = j_q[IdxBits-1:0] - 1'b1;
    in_if.ready = 1'b0;
    out_if.valid = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          rec_we = 1'b1;
          count_d = count_q + 1'b1;
          cur_rec_d = rec_wdata;
          i_d = '0; j_d = '0;
        end
      end
      ST_SORT_RD: begin
        ord_raddr = j_q[IdxBits-1:0] - 1'b1;
      end
      ST_SORT_WAIT: ;
      ST_SORT_CMP: begin
        if (cur_first) begin
          // Shift the later entry up one slot.
          ord_we = 1'b1;
          ord_wdata = ord_rdata;
          j_d = j_q - 1'b1;
        end
      end
      ST_SORT_WR: begin
        ord_we = 1'b1;
        i_d = i_q + 1'b1;
        j_d = i_q + 1'b1;
        rec_raddr = i_q[IdxBits-1:0] + 1'b1;
        if (i_q + 1'b1 == count_q) begin
          i_d = '0; used_d = '0;
        end
      end
      ST_SEL_RD: ord_raddr = i_q[IdxBits-1:0];
      ST_SEL_WAIT: ord_raddr = i_q[IdxBits-1:0];
      ST_SEL_CHK: begin
        if (oth_rec[0] && rec_cost(oth_rec) != '0 &&
            sum_w <= (BudBits+1)'(budget_q)) begin
          used_d = sum_w;
          marks_d[ord_rdata[IdxBits+RecBits-1 -: IdxBits]] = 1'b1;
        end
        i_d = i_q + 1'b1;
        if (i_q + 1'b1 == count_q) i_d = '0;
      end
      ST_EMIT_RD: rec_raddr = i_q[IdxBits-1:0];
      ST_EMIT_WAIT: rec_raddr = i_q[IdxBits-1:0];
      ST_EMIT_OUT: begin
        out_if.valid = 1'b1;
        if (out_if.ready) begin
          i_d = i_q + 1'b1;
          if (i_q + 1'b1 == count_q) begin
            count_d = '0; i_d = '0; marks_d = '0; used_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Output payload from the record memory.
  logic [RecBits-1:0] emit_rec;
  assign emit_rec = rec_rdata;
  always_comb begin
    out_if.out_key = rec_key(emit_rec);
    out_if.out_cost = rec_cost(emit_rec);
    out_if.out_importance = rec_imp(emit_rec);
    out_if.out_visible = emit_rec[0];
    out_if.out_last = (i_q + 1'b1 == count_q);
    if (marks_q[i_q[IdxBits-1:0]])
      out_if.decision = emit_rec[1] ? DEC_KEEP : DEC_LOAD;
    else
      out_if.decision = emit_rec[1] ? DEC_EVICT : DEC_REJECT;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0; i_q <= '0; j_q <= '0; used_q <= '0; marks_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d; i_q <= i_d; j_q <= j_d; used_q <= used_d; marks_q <= marks_d;
    end
  end

  // Current insertion record; arrival 0 is captured straight from the input item.
  logic first_rec_pending_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_rec_pending_q <= 1'b0;
    end else begin
      first_rec_pending_q <= (state_q == ST_SORT_WR);
    end
  end
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD && in_fire && count_q == '0) begin
      cur_rec_q <= cur_rec_d;
    end else if (first_rec_pending_q) begin
      cur_rec_q <= rec_rdata;
    end
  end

  // Terms used by the checks below.
  logic is_load, used_ok, batch_done, batch_clear;
  assign is_load = (state_q == ST_LOAD);
  assign used_ok = (used_q <= (BudBits+1)'(budget_q)) || is_load;
  assign batch_done = out_fire && out_if.out_last;
  assign batch_clear = (marks_q == '0) && (count_q == '0);

  `BRP_ASSERT_IMP(a_no_out_in_load, clk_i, rst_ni, is_load, !out_if.valid, "valid in load")
  `BRP_ASSERT_IMP(a_count_range, clk_i, rst_ni, 1'b1, count_q <= CntBits'(MAX_ASSETS), "count")
  `BRP_ASSERT_IMP(a_used_budget, clk_i, rst_ni, 1'b1, used_ok, "selection exceeds budget")
  `BRP_ASSERT_NEXT(a_marks_clear, clk_i, rst_ni, batch_done, batch_clear, "batch not cleared")
endmodule
